// File: hw/rtl/directed_graph_cycle_detect_defines.svh
// Assertion macros shared by the cycle detector checks
`ifndef DIRECTED_GRAPH_CYCLE_DETECT_DEFINES_SVH
`define DIRECTED_GRAPH_CYCLE_DETECT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define DGCD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cycle detector check failed");

// Next-cycle implication, sampled on clk, off during reset
`define DGCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cycle detector check failed");

`endif

// File: hw/rtl/dgcd_pkg.sv
// Types and codes of the directed graph cycle detector
package dgcd_pkg;

    typedef enum logic
    {
        OP_ADD_EDGE = 1'b0,
        OP_QUERY    = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        COL_UNVISITED = 2'd0,
        COL_ON_WALK   = 2'd1,
        COL_FINISHED  = 2'd2
    } colour_t;

    typedef struct packed
    {
        opcode_t     opcode;
        logic [9:0]  from_vertex;
        logic [9:0]  to_vertex;
    } in_beat_t;

    typedef struct packed
    {
        logic has_cycle;
        logic edge_overflow;
    } out_beat_t;

    typedef enum logic [3:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_OUTER,
        ST_OUTER_CHK,
        ST_OUTER_HEAD,
        ST_EDGE,
        ST_POP,
        ST_TARGET,
        ST_TARGET_CHK,
        ST_PUSH,
        ST_EMIT
    } state_t;

endpackage

// File: hw/rtl/directed_graph_cycle_detect.sv
// Directed graph cycle detector: edge loader and iterative depth-first search
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid / in_ready   | in_data  (opcode, from_vertex, to_vertex)
//  out     | out | out_valid / out_ready | out_data (has_cycle, edge_overflow)
//
// An edge beat does a head read, then a list link write. An edge that is dropped
// (store full or vertex out of range) is taken without leaving the idle state.
// A query beat runs one shared sequencer over memories with one write and one
// registered read port each: a vertex visit steps through OUTER, OUTER_CHK and
// OUTER_HEAD, and each stored edge walked through EDGE, TARGET and TARGET_CHK.
// After reset and after every query, a clearing pass over all MAX_VERTICES entries
// resets the head and colour tables; in_ready stays low meanwhile.
// A finished result waits in the output register; a new query stalls only at
// its end if that register is still full.
module directed_graph_cycle_detect #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dgcd_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dgcd_pkg::out_beat_t out_data
);

    // vertex index, search depth, edge pointer (with empty marker), edge address
    localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DW  = $clog2(MAX_VERTICES + 1);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam logic [EW-1:0] LIST_EMPTY = EW'(MAX_EDGES);

    // memories
    logic [VW-1:0]       tgt_mem  [MAX_EDGES];
    logic [EW-1:0]       nxt_mem  [MAX_EDGES];
    logic [EW-1:0]       head_mem [MAX_VERTICES];
    dgcd_pkg::colour_t   col_mem  [MAX_VERTICES];
    logic [VW+EW-1:0]    stk_mem  [MAX_VERTICES];

    logic                tgt_we, nxt_we, head_we, col_we, stk_we;
    logic [EAW-1:0]      edge_waddr, edge_raddr;
    logic [VW-1:0]       tgt_wdata;
    logic [EW-1:0]       nxt_wdata, head_wdata;
    logic [VW-1:0]       head_waddr, head_raddr, col_waddr, col_raddr;
    logic [VW-1:0]       stk_waddr, stk_raddr;
    dgcd_pkg::colour_t   col_wdata;
    logic [VW+EW-1:0]    stk_wdata;
    logic [VW-1:0]       tgt_rd;
    logic [EW-1:0]       nxt_rd, head_rd;
    dgcd_pkg::colour_t   col_rd;
    logic [VW+EW-1:0]    stk_rd;

    // control and datapath registers
    dgcd_pkg::state_t    state_reg, state_next;
    logic [VW-1:0]       clr_reg, clr_next;
    logic [EW-1:0]       cnt_reg, cnt_next;
    logic [VW-1:0]       largest_reg, largest_next;
    logic                ovf_reg, ovf_next;
    logic [VW-1:0]       from_reg, from_next;
    logic [DW-1:0]       src_reg, src_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic [VW-1:0]       top_v_reg, top_v_next;
    logic [EW-1:0]       top_c_reg, top_c_next;
    logic [VW-1:0]       tgt_reg, tgt_next;
    logic                out_valid_reg, out_valid_next;
    dgcd_pkg::out_beat_t out_reg, out_next;
    logic                found_reg, found_next;

    logic [31:0]         from32, to32;
    logic [VW-1:0]       from_v, to_v;
    logic                vert_ok, store_full;

    assign from32     = 32'(in_data.from_vertex);
    assign to32       = 32'(in_data.to_vertex);
    assign from_v     = from32[VW-1:0];
    assign to_v       = to32[VW-1:0];
    assign vert_ok    = (from32 < 32'(MAX_VERTICES)) && (to32 < 32'(MAX_VERTICES));
    assign store_full = 32'(cnt_reg) >= 32'(MAX_EDGES);

    assign in_ready  = (state_reg == dgcd_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // memory ports: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (tgt_we)
        begin
            tgt_mem[edge_waddr] <= tgt_wdata;
        end
        if (nxt_we)
        begin
            nxt_mem[edge_waddr] <= nxt_wdata;
        end
        tgt_rd <= tgt_mem[edge_raddr];
        nxt_rd <= nxt_mem[edge_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_rd <= head_mem[head_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[col_waddr] <= col_wdata;
        end
        col_rd <= col_mem[col_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rd <= stk_mem[stk_raddr];
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dgcd_pkg::ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            largest_reg   <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            largest_reg   <= largest_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        from_reg  <= from_next;
        src_reg   <= src_next;
        depth_reg <= depth_next;
        top_v_reg <= top_v_next;
        top_c_reg <= top_c_next;
        tgt_reg   <= tgt_next;
        out_reg   <= out_next;
        found_reg <= found_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        largest_next   = largest_reg;
        ovf_next       = ovf_reg;
        from_next      = from_reg;
        src_next       = src_reg;
        depth_next     = depth_reg;
        top_v_next     = top_v_reg;
        top_c_next     = top_c_reg;
        tgt_next       = tgt_reg;
        out_next       = out_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;

        tgt_we     = 1'b0;
        nxt_we     = 1'b0;
        head_we    = 1'b0;
        col_we     = 1'b0;
        stk_we     = 1'b0;
        edge_waddr = cnt_reg[EAW-1:0];
        edge_raddr = top_c_reg[EAW-1:0];
        tgt_wdata  = to_v;
        nxt_wdata  = head_rd;
        head_waddr = from_reg;
        head_wdata = cnt_reg;
        head_raddr = from_v;
        col_waddr  = top_v_reg;
        col_wdata  = dgcd_pkg::COL_FINISHED;
        col_raddr  = src_reg[VW-1:0];
        stk_waddr  = VW'(depth_reg - DW'(1));
        stk_wdata  = {top_v_reg, top_c_reg};
        stk_raddr  = VW'(depth_reg - DW'(2));

        // drop the result beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            dgcd_pkg::ST_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = LIST_EMPTY;
                col_we     = 1'b1;
                col_waddr  = clr_reg;
                col_wdata  = dgcd_pkg::COL_UNVISITED;
                clr_next   = clr_reg + VW'(1);
                if (32'(clr_reg) == 32'(MAX_VERTICES - 1))
                begin
                    clr_next   = '0;
                    state_next = dgcd_pkg::ST_IDLE;
                end
            end

            dgcd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.opcode == dgcd_pkg::OP_QUERY)
                    begin
                        src_next   = '0;
                        found_next = 1'b0;
                        state_next = dgcd_pkg::ST_OUTER;
                    end
                    else if (vert_ok)
                    begin
                        if (store_full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            tgt_we    = 1'b1;
                            from_next = from_v;
                            if (from_v > largest_reg && from_v >= to_v)
                            begin
                                largest_next = from_v;
                            end
                            else if (to_v > largest_reg)
                            begin
                                largest_next = to_v;
                            end
                            state_next = dgcd_pkg::ST_ADD;
                        end
                    end
                end
            end

            dgcd_pkg::ST_ADD:
            begin
                // link the new edge in front of the source's list
                nxt_we     = 1'b1;
                head_we    = 1'b1;
                cnt_next   = cnt_reg + EW'(1);
                state_next = dgcd_pkg::ST_IDLE;
            end

            dgcd_pkg::ST_OUTER:
            begin
                if (32'(src_reg) > 32'(largest_reg) || 32'(src_reg) >= 32'(MAX_VERTICES))
                begin
                    state_next = dgcd_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = dgcd_pkg::ST_OUTER_CHK;
                end
            end

            dgcd_pkg::ST_OUTER_CHK:
            begin
                head_raddr = src_reg[VW-1:0];
                if (col_rd != dgcd_pkg::COL_UNVISITED)
                begin
                    src_next   = src_reg + DW'(1);
                    state_next = dgcd_pkg::ST_OUTER;
                end
                else
                begin
                    col_we     = 1'b1;
                    col_waddr  = src_reg[VW-1:0];
                    col_wdata  = dgcd_pkg::COL_ON_WALK;
                    state_next = dgcd_pkg::ST_OUTER_HEAD;
                end
            end

            dgcd_pkg::ST_OUTER_HEAD:
            begin
                top_v_next = src_reg[VW-1:0];
                top_c_next = head_rd;
                depth_next = DW'(1);
                state_next = dgcd_pkg::ST_EDGE;
            end

            dgcd_pkg::ST_EDGE:
            begin
                if (top_c_reg >= LIST_EMPTY)
                begin
                    // list exhausted: finish vertex, pop a level
                    col_we     = 1'b1;
                    depth_next = depth_reg - DW'(1);
                    if (depth_reg == DW'(1))
                    begin
                        src_next   = src_reg + DW'(1);
                        state_next = dgcd_pkg::ST_OUTER;
                    end
                    else
                    begin
                        state_next = dgcd_pkg::ST_POP;
                    end
                end
                else
                begin
                    state_next = dgcd_pkg::ST_TARGET;
                end
            end

            dgcd_pkg::ST_POP:
            begin
                top_v_next = stk_rd[VW+EW-1:EW];
                top_c_next = stk_rd[EW-1:0];
                state_next = dgcd_pkg::ST_EDGE;
            end

            dgcd_pkg::ST_TARGET:
            begin
                top_c_next = nxt_rd;
                tgt_next   = tgt_rd;
                col_raddr  = tgt_rd;
                state_next = dgcd_pkg::ST_TARGET_CHK;
            end

            dgcd_pkg::ST_TARGET_CHK:
            begin
                head_raddr = tgt_reg;
                if (col_rd == dgcd_pkg::COL_ON_WALK)
                begin
                    found_next = 1'b1;
                    state_next = dgcd_pkg::ST_EMIT;
                end
                else if (col_rd == dgcd_pkg::COL_UNVISITED &&
                         32'(depth_reg) < 32'(MAX_VERTICES))
                begin
                    // save the current level, descend into the target
                    col_we     = 1'b1;
                    col_waddr  = tgt_reg;
                    col_wdata  = dgcd_pkg::COL_ON_WALK;
                    stk_we     = 1'b1;
                    state_next = dgcd_pkg::ST_PUSH;
                end
                else
                begin
                    state_next = dgcd_pkg::ST_EDGE;
                end
            end

            dgcd_pkg::ST_PUSH:
            begin
                top_v_next = tgt_reg;
                top_c_next = head_rd;
                depth_next = depth_reg + DW'(1);
                state_next = dgcd_pkg::ST_EDGE;
            end

            dgcd_pkg::ST_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next         = 1'b1;
                    out_next.has_cycle     = found_reg;
                    out_next.edge_overflow = ovf_reg;
                    cnt_next               = '0;
                    largest_next           = '0;
                    ovf_next               = 1'b0;
                    clr_next               = '0;
                    state_next             = dgcd_pkg::ST_CLEAR;
                end
            end

            default:
            begin
                state_next = dgcd_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// File: hw/rtl/dgcd_checker.sv
// Port-level checks of the cycle detector, bound to the top level
`include "directed_graph_cycle_detect_defines.svh"

module dgcd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input dgcd_pkg::in_beat_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input dgcd_pkg::out_beat_t out_data
);

    `DGCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `DGCD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
    `DGCD_ASSERT_NEXT(a_query_busy, in_valid && in_ready && in_data.opcode == dgcd_pkg::OP_QUERY, !in_ready)
    `DGCD_ASSERT_SAME(a_result_clears, $rose(out_valid), !in_ready)

endmodule

bind directed_graph_cycle_detect dgcd_checker u_dgcd_checker (.*);

// File: test/directed_graph_cycle_detect_test.sv
// Testbench of the directed graph cycle detector: directed table, random graphs, scoreboard
module directed_graph_cycle_detect_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = 1024;
    localparam int NE = 4096;
    localparam int EMPTY = NE;
    localparam longint CYCLE_LIMIT = 64'd2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    dgcd_pkg::in_beat_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    dgcd_pkg::out_beat_t out_data;

    directed_graph_cycle_detect i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always #6 clk = ~clk;

    // Shadow graph: per-vertex edge lists in the same order as the hardware store
    int unsigned g_target[NE];
    int unsigned g_next[NE];
    int unsigned g_head[NV];
    int unsigned g_colour[NV];
    int unsigned walk_vertex[NV];
    int unsigned walk_cursor[NV];
    int unsigned g_edges;
    int unsigned g_largest;
    bit g_overflow;

    dgcd_pkg::out_beat_t verdicts[$];
    int errors = 0;
    longint cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    typedef struct {
        dgcd_pkg::in_beat_t  beat;
        bit                  typed;
        dgcd_pkg::out_beat_t want;
    } table_row_t;

    table_row_t rows[$];

    function automatic void add_row(input dgcd_pkg::in_beat_t b, input bit typed,
                                    input dgcd_pkg::out_beat_t want);
        table_row_t r;
        r.beat = b;
        r.typed = typed;
        r.want = want;
        rows.insert(rows.size(), r);
    endfunction

    function automatic void clear_graph();
        for (int v = 0; v < NV; v++)
        begin
            g_head[v] = EMPTY;
            g_colour[v] = dgcd_pkg::COL_UNVISITED;
        end
        g_edges = 0;
        g_largest = 0;
        g_overflow = 1'b0;
    endfunction

    // Three-color depth-first search with an explicit stack over all vertices up to the largest seen
    function automatic bit graph_has_cycle();
        int unsigned depth;
        int unsigned top;
        int unsigned e;
        int unsigned t;
        for (int unsigned s = 0; s <= g_largest && s < NV; s++)
        begin
            if (g_colour[s] != dgcd_pkg::COL_UNVISITED)
                continue;
            g_colour[s] = dgcd_pkg::COL_ON_WALK;
            walk_vertex[0] = s;
            walk_cursor[0] = g_head[s];
            depth = 1;
            while (depth > 0)
            begin
                top = depth - 1;
                e = walk_cursor[top];
                if (e >= EMPTY)
                begin
                    g_colour[walk_vertex[top]] = dgcd_pkg::COL_FINISHED;
                    depth--;
                    continue;
                end
                walk_cursor[top] = g_next[e];
                t = g_target[e];
                if (g_colour[t] == dgcd_pkg::COL_ON_WALK)
                    return 1'b1;
                if (g_colour[t] == dgcd_pkg::COL_UNVISITED && depth < NV)
                begin
                    g_colour[t] = dgcd_pkg::COL_ON_WALK;
                    walk_vertex[depth] = t;
                    walk_cursor[depth] = g_head[t];
                    depth++;
                end
            end
        end
        return 1'b0;
    endfunction

    // Advance the shadow graph by one beat; return 1 with the verdict on a query
    function automatic bit graph_step(input dgcd_pkg::in_beat_t b,
                                      output dgcd_pkg::out_beat_t v);
        v = '0;
        if (b.opcode == dgcd_pkg::OP_ADD_EDGE)
        begin
            if (g_edges >= NE)
            begin
                g_overflow = 1'b1;
                return 1'b0;
            end
            if (b.from_vertex > g_largest)
                g_largest = b.from_vertex;
            if (b.to_vertex > g_largest)
                g_largest = b.to_vertex;
            g_target[g_edges] = b.to_vertex;
            g_next[g_edges] = g_head[b.from_vertex];
            g_head[b.from_vertex] = g_edges;
            g_edges++;
            return 1'b0;
        end
        v.has_cycle = graph_has_cycle();
        v.edge_overflow = g_overflow;
        clear_graph();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // Drive one beat: drop valid for random idle cycles, then hold it until accepted
    task automatic send_beat(input dgcd_pkg::in_beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Predict and queue; typed rows also pin the verdict by hand
    task automatic send_checked(input dgcd_pkg::in_beat_t b, input bit typed,
                                input dgcd_pkg::out_beat_t want);
        dgcd_pkg::out_beat_t v;
        if (graph_step(b, v))
        begin
            if (typed && v !== want)
                report_mismatch("predictor disagrees with typed verdict");
            verdicts.insert(verdicts.size(), typed ? want : v);
        end
        send_beat(b);
    endtask

    function automatic dgcd_pkg::in_beat_t edge_beat(input int f, input int t);
        dgcd_pkg::in_beat_t b;
        b.opcode = dgcd_pkg::OP_ADD_EDGE;
        b.from_vertex = f[9:0];
        b.to_vertex = t[9:0];
        return b;
    endfunction

    function automatic dgcd_pkg::in_beat_t query_beat(input bit [9:0] f, input bit [9:0] t);
        dgcd_pkg::in_beat_t b;
        b.opcode = dgcd_pkg::OP_QUERY;
        b.from_vertex = f;
        b.to_vertex = t;
        return b;
    endfunction

    // Random graph of n arcs over vertices base..base+span; acyclic when dag is set (arcs then go upward)
    task automatic send_random_graph(input int n, input int span, input bit dag);
        int f;
        int t;
        int base;
        base = $urandom_range(1023 - span);
        for (int k = 0; k < n; k++)
        begin
            f = $urandom_range(span);
            t = $urandom_range(span);
            if (dag && f >= t)
            begin
                if (f == t)
                    t = (f == span) ? 0 : f + 1;
                if (f > t)
                begin
                    int x;
                    x = f;
                    f = t;
                    t = x;
                end
            end
            send_checked(edge_beat(base + f, base + t), 1'b0, '0);
        end
        send_checked(query_beat(10'($urandom), 10'($urandom)), 1'b0, '0);
    endtask

    // Receiver: stall at random, check each beat against the oldest verdict
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdicts.size() == 0)
                report_mismatch("result beat with no verdict waiting");
            else
            begin
                dgcd_pkg::out_beat_t w;
                w = verdicts.pop_front();
                if (out_data.has_cycle !== w.has_cycle)
                    report_mismatch($sformatf("has_cycle %b, want %b",
                        out_data.has_cycle, w.has_cycle));
                if (out_data.edge_overflow !== w.edge_overflow)
                    report_mismatch($sformatf("edge_overflow %b, want %b",
                        out_data.edge_overflow, w.edge_overflow));
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d", cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        dgcd_pkg::out_beat_t no_cycle;
        dgcd_pkg::out_beat_t cyc;
        no_cycle = '0;
        cyc = '0;
        cyc.has_cycle = 1'b1;
        clear_graph();

        // Empty query after reset, self-loops at the extremes, chains and two-vertex loops
        add_row(query_beat(10'h3FF, 10'h000), 1'b1, no_cycle);
        add_row(edge_beat(0, 0), 1'b0, '0);
        add_row(query_beat(10'h000, 10'h3FF), 1'b1, cyc);
        add_row(edge_beat(1023, 1023), 1'b0, '0);
        add_row(query_beat(10'h2AA, 10'h155), 1'b1, cyc);
        add_row(edge_beat(0, 1023), 1'b0, '0);
        add_row(edge_beat(1023, 512), 1'b0, '0);
        add_row(query_beat(10'h155, 10'h2AA), 1'b1, no_cycle);
        add_row(edge_beat(341, 682), 1'b0, '0);
        add_row(edge_beat(682, 341), 1'b0, '0);
        add_row(query_beat(10'h000, 10'h000), 1'b1, cyc);
        add_row(edge_beat(5, 6), 1'b0, '0);
        add_row(edge_beat(6, 7), 1'b0, '0);
        add_row(edge_beat(5, 7), 1'b0, '0);
        add_row(edge_beat(7, 5), 1'b0, '0);
        add_row(query_beat(10'h3FF, 10'h3FF), 1'b0, '0);
        add_row(edge_beat(9, 3), 1'b0, '0);
        add_row(edge_beat(3, 9), 1'b0, '0);
        add_row(edge_beat(2, 2), 1'b0, '0);
        add_row(query_beat(10'h001, 10'h002), 1'b0, '0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            send_checked(rows[i].beat, rows[i].typed, rows[i].want);

        // Random phases: no idling, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            for (int q = 0; q < 17; q++)
            begin
                // Mostly small graphs, two in three acyclic; some wide-spread ones, half acyclic
                if ($urandom_range(9) == 0)
                    send_random_graph($urandom_range(1, 20), 1023, $urandom_range(1));
                else
                    send_random_graph($urandom_range(1, 14), $urandom_range(1, 12),
                        $urandom_range(2) != 0);
            end
        end
        in_valid <= 1'b0;

        while (verdicts.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
